[rtl/random_tie_break_selector_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the random tie-break selector
// Immediate-implication and next-cycle checks, clocked on clk, held off in rst.
// ----------------------------------------------------------------------------
`ifndef RANDOM_TIE_BREAK_SELECTOR_TOP_ASSERT_SVH
`define RANDOM_TIE_BREAK_SELECTOR_TOP_ASSERT_SVH

// ante |-> cons in the same cycle
`define RTSEL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante |=> cons in the following cycle
`define RTSEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rtsel_pkg.sv]
// ----------------------------------------------------------------------------
// rtsel_pkg
// Shared types, constants and the small modulo-3 helper of the selector.
// ----------------------------------------------------------------------------
package rtsel_pkg;

  localparam int STATE_W  = 64;
  localparam int MASK_W   = 3;
  localparam int IDX_W    = 2;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 4;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [0:0] REG_SEED = 1'b0;

  localparam logic [STATE_W-1:0] LCG_ADD = 64'h2492492492492479;
  localparam logic [STATE_W-1:0] MIX_K1  = 64'hbf58476d1ce4e5b9;
  localparam logic [STATE_W-1:0] MIX_K2  = 64'h94d049bb133111eb;
  localparam int MIX_SH1 = 30;
  localparam int MIX_SH2 = 27;
  localparam int MIX_SH3 = 31;

  typedef enum logic [1:0] {
    KIND_FIXED  = 2'd0,
    KIND_PAIR   = 2'd1,
    KIND_TRIPLE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    logic               empty_req;
    logic [STATE_W-1:0] state;
  } item_t;

  // 10-bit value modulo 3: base-4 digit folding, then two conditional subtracts
  function automatic logic [IDX_W-1:0] mod3_10(input logic [9:0] c);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(c[1:0]) + 4'(c[3:2]) + 4'(c[5:4]) + 4'(c[7:6]) + 4'(c[9:8]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    return t[IDX_W-1:0];
  endfunction

endpackage

[rtl/random_tie_break_selector_top.sv]
// ----------------------------------------------------------------------------
// random_tie_break_selector_top
// Picks one eligible candidate of three; ties broken by an LCG plus finalizer.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer when
//  request   push, full, request_mask                push && !full
//  result    pop, empty, chosen_index, empty_request pop && !empty
//  config    psel, penable, pwrite, paddr, pwdata    psel && penable && pwrite
//
//  The front takes one request per cycle, while not full, into a two-entry queue.
//  Back end: an empty or single mask goes straight to the result register; a
//  pair or all three run the hash on one shared 32x32 multiplier first.
//  A waiting result does not block the front until the queue fills.
//  rst is synchronous; seed and generator state reset to zero.
// ----------------------------------------------------------------------------
module random_tie_break_selector_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtsel_pkg::ADDR_W-1:0]  paddr,
  input  logic [rtsel_pkg::DATA_W-1:0]  pwdata,
  output logic [rtsel_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic [rtsel_pkg::MASK_W-1:0]  request_mask,
  output logic                          empty,
  input  logic                          pop,
  output logic [rtsel_pkg::IDX_W-1:0]   chosen_index,
  output logic                          empty_request
);

  logic             q_full;
  logic             q_empty;
  logic             q_wr;
  logic             q_rd;
  rtsel_pkg::item_t q_wr_item;
  rtsel_pkg::item_t q_rd_item;

  rtsel_front u_front (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .push         (push),
    .request_mask (request_mask),
    .full         (full),
    .q_full       (q_full),
    .q_push       (q_wr),
    .q_item       (q_wr_item)
  );

  rtsel_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (q_wr_item),
    .full    (q_full),
    .rd      (q_rd),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  rtsel_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_item        (q_rd_item),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .chosen_index  (chosen_index),
    .empty_request (empty_request)
  );

endmodule

[rtl/rtsel_front.sv]
// ----------------------------------------------------------------------------
// rtsel_front
// Seed register, LCG state, request classification and queue push.
// ----------------------------------------------------------------------------
module rtsel_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtsel_pkg::ADDR_W-1:0]  paddr,
  input  logic [rtsel_pkg::DATA_W-1:0]  pwdata,
  output logic [rtsel_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          push,
  input  logic [rtsel_pkg::MASK_W-1:0]  request_mask,
  output logic                          full,
  input  logic                          q_full,
  output logic                          q_push,
  output rtsel_pkg::item_t              q_item
);

  logic [rtsel_pkg::STATE_W-1:0] seed;
  logic [rtsel_pkg::STATE_W-1:0] gen_state;
  logic [rtsel_pkg::STATE_W-1:0] gen_state_next;
  logic                          seed_wr;
  logic                          multi;

  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && pready
                   && (paddr[rtsel_pkg::ADDR_W-1] == rtsel_pkg::REG_SEED);
  assign prdata  = (paddr[rtsel_pkg::ADDR_W-1] == rtsel_pkg::REG_SEED) ? seed : '0;

  assign full   = q_full;
  assign q_push = push && !q_full;

  // state * 0x1010101 + add, as shifted adds
  assign gen_state_next = gen_state + (gen_state << 8) + (gen_state << 16)
                          + (gen_state << 24) + rtsel_pkg::LCG_ADD;

  always_comb begin
    multi            = 1'b1;
    q_item.kind      = rtsel_pkg::KIND_PAIR;
    q_item.lo        = 2'd0;
    q_item.hi        = 2'd1;
    q_item.empty_req = 1'b0;
    case (request_mask)
      3'b000: begin
        multi            = 1'b0;
        q_item.kind      = rtsel_pkg::KIND_FIXED;
        q_item.empty_req = 1'b1;
      end
      3'b001: begin
        multi       = 1'b0;
        q_item.kind = rtsel_pkg::KIND_FIXED;
        q_item.lo   = 2'd0;
      end
      3'b010: begin
        multi       = 1'b0;
        q_item.kind = rtsel_pkg::KIND_FIXED;
        q_item.lo   = 2'd1;
      end
      3'b100: begin
        multi       = 1'b0;
        q_item.kind = rtsel_pkg::KIND_FIXED;
        q_item.lo   = 2'd2;
      end
      3'b011: begin
        q_item.lo = 2'd0;
        q_item.hi = 2'd1;
      end
      3'b101: begin
        q_item.lo = 2'd0;
        q_item.hi = 2'd2;
      end
      3'b110: begin
        q_item.lo = 2'd1;
        q_item.hi = 2'd2;
      end
      default: begin
        q_item.kind = rtsel_pkg::KIND_TRIPLE;
      end
    endcase
    q_item.state = gen_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      gen_state <= '0;
    end else if (seed_wr) begin
      seed      <= pwdata;
      gen_state <= pwdata;
    end else if (q_push && multi) begin
      gen_state <= gen_state_next;
    end
  end

endmodule

[rtl/rtsel_queue.sv]
// ----------------------------------------------------------------------------
// rtsel_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`include "random_tie_break_selector_top_assert.svh"

module rtsel_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  rtsel_pkg::item_t  wr_item,
  output logic              full,
  input  logic              rd,
  output rtsel_pkg::item_t  rd_item,
  output logic              empty
);

  rtsel_pkg::item_t               entries [rtsel_pkg::QDEPTH];
  logic [rtsel_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rtsel_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rtsel_pkg::QCNT_W-1:0]   count;

  assign full    = (count == rtsel_pkg::QCNT_W'(rtsel_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == rtsel_pkg::QPTR_W'(rtsel_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == rtsel_pkg::QPTR_W'(rtsel_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `RTSEL_ASSERT_NOW(a_q_no_overflow, wr, !full || rd, "queue written while full")
  `RTSEL_ASSERT_NOW(a_q_no_underflow, rd, !empty, "queue read while empty")
  `RTSEL_ASSERT_NOW(a_q_count_max, 1'b1, count <= rtsel_pkg::QCNT_W'(rtsel_pkg::QDEPTH),
    "queue count beyond depth")

endmodule

[rtl/rtsel_back.sv]
// ----------------------------------------------------------------------------
// rtsel_back
// Finalizer hash on a shared 32x32 multiplier, modulo pick and result register.
// ----------------------------------------------------------------------------
`include "random_tie_break_selector_top_assert.svh"

module rtsel_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  rtsel_pkg::item_t              q_item,
  output logic                          q_rd,
  output logic                          empty,
  input  logic                          pop,
  output logic [rtsel_pkg::IDX_W-1:0]   chosen_index,
  output logic                          empty_request
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_FOLD1 = 5'b00100,
    ST_FOLD2 = 5'b01000,
    ST_DONE  = 5'b10000
  } back_state_t;

  back_state_t                   st;
  back_state_t                   st_next;
  rtsel_pkg::kind_t              kind;
  logic [rtsel_pkg::IDX_W-1:0]   lo;
  logic [rtsel_pkg::IDX_W-1:0]   hi;
  logic [rtsel_pkg::STATE_W-1:0] v;
  logic [rtsel_pkg::STATE_W-1:0] acc;
  logic [rtsel_pkg::STATE_W-1:0] acc_sum;
  logic [rtsel_pkg::STATE_W-1:0] prod;
  logic [rtsel_pkg::STATE_W-1:0] mul;
  logic [rtsel_pkg::STATE_W-1:0] k;
  logic [31:0]                   mul_a;
  logic [31:0]                   mul_b;
  logic [1:0]                    step;
  logic                          round;
  logic [32:0]                   red;
  logic [17:0]                   red2;
  logic [9:0]                    red3;
  logic [rtsel_pkg::IDX_W-1:0]   pick;
  logic                          out_valid;
  logic                          out_free;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  assign q_rd = (st == ST_IDLE) && !q_empty
                && ((q_item.kind != rtsel_pkg::KIND_FIXED) || out_free);

  assign k       = round ? rtsel_pkg::MIX_K2 : rtsel_pkg::MIX_K1;
  assign mul_a   = (step == 2'd2) ? v[63:32] : v[31:0];
  assign mul_b   = (step == 2'd1) ? k[63:32] : k[31:0];
  assign mul     = 64'(mul_a) * 64'(mul_b);
  assign acc_sum = acc + {prod[31:0], 32'b0};

  assign red2 = 18'(red[15:0]) + 18'(red[32:16]);
  assign red3 = 10'(red2[7:0]) + 10'(red2[17:8]);

  always_comb begin
    case (kind)
      rtsel_pkg::KIND_PAIR:   pick = v[0] ? hi : lo;
      rtsel_pkg::KIND_TRIPLE: pick = rtsel_pkg::mod3_10(red[9:0]);
      default:                pick = lo;
    endcase
  end

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (q_rd && (q_item.kind != rtsel_pkg::KIND_FIXED)) begin
          st_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (step == 2'd3 && round) begin
          st_next = (kind == rtsel_pkg::KIND_TRIPLE) ? ST_FOLD1 : ST_DONE;
        end
      end
      ST_FOLD1: st_next = ST_FOLD2;
      ST_FOLD2: st_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        if (q_rd) begin
          kind  <= q_item.kind;
          lo    <= q_item.lo;
          hi    <= q_item.hi;
          v     <= q_item.state ^ (q_item.state >> rtsel_pkg::MIX_SH1);
          step  <= 2'd0;
          round <= 1'b0;
        end
      end
      ST_MUL: begin
        prod <= mul;
        step <= step + 2'd1;
        case (step)
          2'd1: acc <= prod;
          2'd2: acc <= acc_sum;
          2'd3: begin
            if (!round) begin
              v     <= acc_sum ^ (acc_sum >> rtsel_pkg::MIX_SH2);
              round <= 1'b1;
            end else begin
              v <= acc_sum ^ (acc_sum >> rtsel_pkg::MIX_SH3);
            end
          end
          default: acc <= acc;
        endcase
      end
      ST_FOLD1: red <= 33'(v[31:0]) + 33'(v[63:32]);
      ST_FOLD2: red <= 33'(red3);
      default: red <= red;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((q_rd && q_item.kind == rtsel_pkg::KIND_FIXED)
                 || (st == ST_DONE && out_free)) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && q_item.kind == rtsel_pkg::KIND_FIXED) begin
      chosen_index  <= q_item.lo;
      empty_request <= q_item.empty_req;
    end else if (st == ST_DONE && out_free) begin
      chosen_index  <= pick;
      empty_request <= 1'b0;
    end
  end

  `RTSEL_ASSERT_NEXT(a_out_hold, out_valid && !pop, out_valid && $stable(chosen_index),
    "result dropped or changed while stalled")
  `RTSEL_ASSERT_NOW(a_idx_range, out_valid, chosen_index != 2'd3, "chosen index out of range")
  `RTSEL_ASSERT_NOW(a_empty_idx, out_valid && empty_request, chosen_index == 2'd0,
    "empty request with nonzero index")

endmodule

[dv/tb_random_tie_break_selector_top.sv]
// ----------------------------------------------------------------------------
// tb_random_tie_break_selector_top
// Self-checking bench for the tie-break selector. Drives eligibility masks
// through the push/full side, programs the seed over APB, and checks every
// popped result against a local LCG + finalizer model of the pick logic.
// ----------------------------------------------------------------------------
module tb_random_tie_break_selector_top;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned IDLE_PCT    = 31;
  localparam int unsigned MAX_PRINTS  = 40;

  localparam logic [rtsel_pkg::ADDR_W-1:0] SEED_ADDR =
    rtsel_pkg::ADDR_W'(8 * int'(rtsel_pkg::REG_SEED));
  localparam logic [63:0] LCG_MUL = 64'h0000_0000_0101_0101;

  typedef struct {
    logic [rtsel_pkg::IDX_W-1:0] index;
    logic                        empty_flag;
  } pick_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [rtsel_pkg::ADDR_W-1:0]      paddr = '0;
  logic [rtsel_pkg::DATA_W-1:0]      pwdata = '0;
  logic [rtsel_pkg::DATA_W-1:0]      prdata;
  logic                              pready;
  logic                              push = 1'b0;
  logic                              full;
  logic [rtsel_pkg::MASK_W-1:0]      request_mask = '0;
  logic                              empty;
  logic                              pop = 1'b0;
  logic [rtsel_pkg::IDX_W-1:0]       chosen_index;
  logic                              empty_request;

  logic [63:0]  lcg_state = '0;
  pick_t        pending_picks[$];
  int unsigned  errors = 0;
  int unsigned  cycle_count = 0;
  bit           send_idle_en = 1'b0;
  bit           recv_idle_en = 1'b0;
  bit           receiver_hold = 1'b0;

  random_tie_break_selector_top u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .request_mask  (request_mask),
    .empty         (empty),
    .pop           (pop),
    .chosen_index  (chosen_index),
    .empty_request (empty_request)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (errors < MAX_PRINTS)
      $display("MISMATCH %s: expected %0h, got %0h (cycle %0d)", what, want, got,
               cycle_count);
    errors++;
  endtask

  // splitmix64 finalizer, salt zero
  function automatic logic [63:0] finalize_hash(input logic [63:0] v);
    v = (v ^ (v >> rtsel_pkg::MIX_SH1)) * rtsel_pkg::MIX_K1;
    v = (v ^ (v >> rtsel_pkg::MIX_SH2)) * rtsel_pkg::MIX_K2;
    v = v ^ (v >> rtsel_pkg::MIX_SH3);
    return v;
  endfunction

  function automatic logic [63:0] advance_generator();
    lcg_state = lcg_state * LCG_MUL + rtsel_pkg::LCG_ADD;
    return finalize_hash(lcg_state);
  endfunction

  task automatic record_request(input logic [rtsel_pkg::MASK_W-1:0] mask);
    pick_t       p;
    logic [63:0] h;
    p.index      = '0;
    p.empty_flag = (mask == '0);
    case (mask)
      3'b001: p.index = 2'd0;
      3'b010: p.index = 2'd1;
      3'b100: p.index = 2'd2;
      3'b011: begin
        h = advance_generator();
        p.index = h[0] ? 2'd1 : 2'd0;
      end
      3'b101: begin
        h = advance_generator();
        p.index = h[0] ? 2'd2 : 2'd0;
      end
      3'b110: begin
        h = advance_generator();
        p.index = h[0] ? 2'd2 : 2'd1;
      end
      3'b111: begin
        h = advance_generator();
        p.index = 2'(h % 64'd3);
      end
      default: p.index = 2'd0;
    endcase
    pending_picks.push_back(p);
  endtask

  always @(negedge clk) begin
    if (receiver_hold)
      pop <= 1'b0;
    else if (recv_idle_en)
      pop <= ($urandom_range(0, 99) >= IDLE_PCT);
    else
      pop <= 1'b1;
  end

  always @(posedge clk) begin : check_results
    pick_t want;
    if (!rst && pop && !empty) begin
      if (pending_picks.size() == 0) begin
        report_mismatch("result with nothing pending", 64'd0, 64'(chosen_index));
      end else begin
        want = pending_picks.pop_front();
        if (chosen_index !== want.index)
          report_mismatch("chosen_index", 64'(want.index), 64'(chosen_index));
        if (empty_request !== want.empty_flag)
          report_mismatch("empty_request", 64'(want.empty_flag), 64'(empty_request));
      end
    end
  end

  task automatic send_request(input logic [rtsel_pkg::MASK_W-1:0] mask);
    @(negedge clk);
    while (send_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      push = 1'b0;
      request_mask = rtsel_pkg::MASK_W'($urandom);
      @(negedge clk);
    end
    push = 1'b1;
    request_mask = mask;
    @(posedge clk);
    while (full) @(posedge clk);
    record_request(mask);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    push = 1'b0;
    @(posedge clk);
    while (pending_picks.size() != 0) @(posedge clk);
  endtask

  // seed write then readback; only called with nothing in flight
  task automatic write_seed(input logic [63:0] value);
    logic [63:0] readback;
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = SEED_ADDR; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    lcg_state = value;
    @(negedge clk);
    penable = 1'b0; pwrite = 1'b0; pwdata = ~value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
    if (readback !== value) report_mismatch("seed readback", value, readback);
    @(posedge clk);
  endtask

  // every mask with the reset seed, then repeated ties to walk the generator
  task automatic test_directed_masks();
    logic [rtsel_pkg::MASK_W-1:0] ties[4] = '{3'b011, 3'b101, 3'b110, 3'b111};
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    for (int m = 0; m < 8; m++) send_request(rtsel_pkg::MASK_W'(m));
    for (int r = 0; r < 3; r++)
      foreach (ties[i]) send_request(ties[i]);
    wait_for_results();
  endtask

  task automatic test_seed_extremes();
    logic [63:0] seeds[3] = '{64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'd1};
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      for (int n = 0; n < 12; n++) send_request(3'b011 + 3'(n % 5));
      wait_for_results();
    end
  endtask

  task automatic test_random_traffic(input logic [63:0] seed, input int unsigned count,
                                     input bit with_idles);
    int unsigned roll;
    send_idle_en = with_idles;
    recv_idle_en = with_idles;
    write_seed(seed);
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 65)
        send_request((roll % 4 == 0) ? 3'b011 : (roll % 4 == 1) ? 3'b101 :
                     (roll % 4 == 2) ? 3'b110 : 3'b111);
      else
        send_request(rtsel_pkg::MASK_W'($urandom));
    end
    wait_for_results();
  endtask

  // receiver stalls long enough for the request side to back up
  task automatic test_backpressure();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b1;
    write_seed({$urandom, $urandom});
    fork
      begin
        receiver_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold = 1'b0;
      end
    join_none
    for (int n = 0; n < 40; n++) send_request(rtsel_pkg::MASK_W'($urandom));
    wait_for_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    test_directed_masks();
    test_seed_extremes();
    test_random_traffic({$urandom, $urandom}, 160, 1'b1);
    test_random_traffic(64'hffff_ffff_ffff_ffff, 160, 1'b1);
    test_random_traffic({$urandom, $urandom}, 180, 1'b0);
    test_random_traffic(64'd0, 160, 1'b1);
    test_backpressure();
    test_random_traffic({$urandom, $urandom}, 140, 1'b1);

    recv_idle_en = 1'b0;
    repeat (30) @(posedge clk);
    if (pending_picks.size() != 0)
      report_mismatch("results never returned", 64'(pending_picks.size()), 64'd0);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rtsel_pkg.sv
rtl/rtsel_front.sv
rtl/rtsel_queue.sv
rtl/rtsel_back.sv
rtl/random_tie_break_selector_top.sv
dv/tb_random_tie_break_selector_top.sv
